// ----- rtl/bdq_pkg.sv -----
// bounded deque package: sizes, codes, payload and control types
package bdq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned PTR_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OCC_W   = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SHOW       = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY    = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] data;
    logic [OCC_W-1:0]         occupancy;
    logic                     last;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SHOW
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_SHOW,
    OP_STEP
  } op_e;

  // controller to datapath
  typedef struct packed {
    op_e               op;
    logic              load;
    logic [STAT_W-1:0] status;
    logic              use_rd;
    logic              last;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic out_busy;
    logic show_last;
  } dp_stat_t;

endpackage

// ----- rtl/bdq_datapath.sv -----
// bounded deque datapath: circular store, pointers, count and result register
module bdq_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bdq_pkg::ctrl_cmd_t  cmd_i,
  input  logic signed [bdq_pkg::WORD_W-1:0] value_i,
  input  logic                out_ready_i,
  output bdq_pkg::dp_stat_t   stat_o,
  output logic                out_valid_o,
  output bdq_pkg::out_item_t  out_data_o
);

  localparam int unsigned PW = bdq_pkg::PTR_W;
  localparam int unsigned CW = bdq_pkg::CNT_W;

  function automatic logic [PW-1:0] idx_next(input logic [PW-1:0] i);
    return (i == PW'(bdq_pkg::DEPTH - 1)) ? '0 : i + PW'(1);
  endfunction

  function automatic logic [PW-1:0] idx_prev(input logic [PW-1:0] i);
    return (i == '0) ? PW'(bdq_pkg::DEPTH - 1) : i - PW'(1);
  endfunction

  logic [bdq_pkg::WORD_W-1:0] mem_q [bdq_pkg::DEPTH];
  logic [bdq_pkg::WORD_W-1:0] rdata_q;

  logic [PW-1:0] head_q, head_d, tail_q, tail_d, walk_q, walk_d;
  logic [CW-1:0] held_q, held_d, left_q, left_d;
  logic [PW-1:0] waddr, raddr;
  logic          we;

  logic               out_valid_q, out_valid_d;
  bdq_pkg::out_item_t out_q, out_d;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    held_d = held_q;
    walk_d = walk_q;
    left_d = left_q;
    we     = 1'b0;
    waddr  = tail_q;
    raddr  = walk_q;
    unique case (cmd_i.op)
      bdq_pkg::OP_PUSH_FRONT: begin
        head_d = idx_prev(head_q);
        waddr  = idx_prev(head_q);
        we     = 1'b1;
        held_d = held_q + CW'(1);
      end
      bdq_pkg::OP_PUSH_BACK: begin
        waddr  = tail_q;
        we     = 1'b1;
        tail_d = idx_next(tail_q);
        held_d = held_q + CW'(1);
      end
      bdq_pkg::OP_POP_FRONT: begin
        raddr  = head_q;
        head_d = idx_next(head_q);
        held_d = held_q - CW'(1);
      end
      bdq_pkg::OP_POP_BACK: begin
        raddr  = idx_prev(tail_q);
        tail_d = idx_prev(tail_q);
        held_d = held_q - CW'(1);
      end
      bdq_pkg::OP_SHOW: begin
        raddr  = head_q;
        walk_d = head_q;
        left_d = held_q;
      end
      bdq_pkg::OP_STEP: begin
        raddr  = idx_next(walk_q);
        walk_d = idx_next(walk_q);
        left_d = left_q - CW'(1);
      end
      bdq_pkg::OP_NONE: begin
        raddr = walk_q;
      end
      default: begin
        raddr = walk_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= value_i;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      held_q <= '0;
      walk_q <= '0;
      left_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      held_q <= held_d;
      walk_q <= walk_d;
      left_q <= left_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (cmd_i.load) begin
      out_valid_d     = 1'b1;
      out_d.status    = cmd_i.status;
      out_d.data      = cmd_i.use_rd ? rdata_q : '0;
      out_d.occupancy = bdq_pkg::OCC_W'(held_d);
      out_d.last      = cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign stat_o.full      = (held_q == CW'(bdq_pkg::DEPTH));
  assign stat_o.empty     = (held_q == '0);
  assign stat_o.out_busy  = out_valid_q;
  assign stat_o.show_last = (left_q == CW'(1));

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(bdq_pkg::DEPTH))
    else $error("word count above depth");

  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == '0 || held_q == CW'(bdq_pkg::DEPTH)) |-> head_q == tail_q)
    else $error("head and tail apart on empty or full deque");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && out_valid_q) |-> out_ready_i)
    else $error("pending result overwritten");
`endif

endmodule

// ----- rtl/bdq_ctrl.sv -----
// bounded deque controller: command decode and show sequencing
module bdq_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [bdq_pkg::CMD_W-1:0] command_i,
  input  logic                    out_ready_i,
  input  bdq_pkg::dp_stat_t       stat_i,
  output logic                    in_ready_o,
  output bdq_pkg::ctrl_cmd_t      cmd_o
);

  bdq_pkg::state_e state_q, state_d;
  logic            slot_free;
  logic            accept;

  assign slot_free = !stat_i.out_busy || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    accept        = 1'b0;
    cmd_o.op      = bdq_pkg::OP_NONE;
    cmd_o.load    = 1'b0;
    cmd_o.status  = bdq_pkg::STATUS_OK;
    cmd_o.use_rd  = 1'b0;
    cmd_o.last    = 1'b1;
    unique case (state_q)
      bdq_pkg::S_IDLE: begin
        in_ready_o = slot_free;
        accept     = in_valid_i && slot_free;
        if (accept) begin
          priority case (command_i)
            bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
              cmd_o.load = 1'b1;
              if (stat_i.full) begin
                cmd_o.status = bdq_pkg::STATUS_OVERFLOW;
              end else begin
                cmd_o.op = (command_i == bdq_pkg::CMD_PUSH_FRONT) ?
                           bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_BACK;
              end
            end
            bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK: begin
              if (stat_i.empty) begin
                cmd_o.load   = 1'b1;
                cmd_o.status = bdq_pkg::STATUS_EMPTY;
              end else begin
                cmd_o.op = (command_i == bdq_pkg::CMD_POP_FRONT) ?
                           bdq_pkg::OP_POP_FRONT : bdq_pkg::OP_POP_BACK;
                state_d  = bdq_pkg::S_POP;
              end
            end
            bdq_pkg::CMD_SHOW: begin
              if (stat_i.empty) begin
                cmd_o.load   = 1'b1;
                cmd_o.status = bdq_pkg::STATUS_EMPTY;
              end else begin
                cmd_o.op = bdq_pkg::OP_SHOW;
                state_d  = bdq_pkg::S_SHOW;
              end
            end
            default: begin
              // unused command codes are dropped without a result
            end
          endcase
        end
      end
      bdq_pkg::S_POP: begin
        cmd_o.load   = 1'b1;
        cmd_o.use_rd = 1'b1;
        state_d      = bdq_pkg::S_IDLE;
      end
      bdq_pkg::S_SHOW: begin
        if (slot_free) begin
          cmd_o.load   = 1'b1;
          cmd_o.use_rd = 1'b1;
          cmd_o.last   = stat_i.show_last;
          if (stat_i.show_last) begin
            state_d = bdq_pkg::S_IDLE;
          end else begin
            cmd_o.op = bdq_pkg::OP_STEP;
          end
        end
      end
      default: begin
        state_d = bdq_pkg::S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_pop_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bdq_pkg::S_POP |-> !stat_i.out_busy)
    else $error("pop result with result register still occupied");

  a_pop_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bdq_pkg::S_POP |=> state_q == bdq_pkg::S_IDLE)
    else $error("pop did not return to idle");
`endif

endmodule

// ----- rtl/bounded_deque_unit.sv -----
// bounded deque top level: controller and datapath
//
// bounded double-ended queue of signed 32-bit words held in a circular store
// of bdq_pkg::DEPTH entries (16), with push front, push back, pop front, pop
// back and show commands. every accepted transaction gives one result except
// show on a non-empty deque, which gives one result per held word from front
// to rear with last set on the rear word, and unused command codes, which give
// none. a push on a full deque answers overflow and leaves the store alone; a
// pop or show on an empty deque answers empty with data zero. occupancy is the
// word count after the command. timing: pushes, and any command answered with
// overflow or empty, are answered from the idle state; a pop passes through
// the pop state because the store has one registered read port; a show gives
// one word per cycle through that same read port while the result register
// is free. the result sits in an output register, so the next transaction is
// taken in the cycle the previous result is taken, or at once if the register
// is empty; out_ready low stalls the unit. reset clears head, tail and count;
// store contents need no clearing since only held words are ever read.
module bounded_deque_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bdq_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bdq_pkg::out_item_t  out_data_o
);

  // command and status between the two halves
  bdq_pkg::ctrl_cmd_t ctrl_cmd;
  bdq_pkg::dp_stat_t  dp_stat;

  // decodes each transaction and walks the store during show
  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (in_data_i.command),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .in_ready_o  (in_ready_o),
    .cmd_o       (ctrl_cmd)
  );

  // store, pointers, count and the output result register
  bdq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .value_i     (in_data_i.value),
    .out_ready_i (out_ready_i),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the bounded deque unit with a shadow deque predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // clock, reset and the two valid/ready channels of the unit
  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  bdq_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  bdq_pkg::out_item_t out_data_o;

  bounded_deque_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the deque: circular store, front index, one-past-rear index, word count
  logic signed [bdq_pkg::WORD_W-1:0] shadow_store [bdq_pkg::DEPTH];
  logic [bdq_pkg::PTR_W-1:0]         shadow_head;
  logic [bdq_pkg::PTR_W-1:0]         shadow_tail;
  logic [bdq_pkg::CNT_W-1:0]         shadow_count;

  // results the unit still owes, oldest first
  bdq_pkg::out_item_t due_results [$];

  int  fail_count = 0;
  // per-side idling switches, flipped by the test tasks
  bit  send_idle  = 1'b1;
  bit  recv_idle  = 1'b1;

  function automatic logic [bdq_pkg::PTR_W-1:0] ptr_next(
    input logic [bdq_pkg::PTR_W-1:0] p);
    return (p == bdq_pkg::PTR_W'(bdq_pkg::DEPTH - 1)) ? '0 : p + bdq_pkg::PTR_W'(1);
  endfunction

  function automatic logic [bdq_pkg::PTR_W-1:0] ptr_prev(
    input logic [bdq_pkg::PTR_W-1:0] p);
    return (p == '0) ? bdq_pkg::PTR_W'(bdq_pkg::DEPTH - 1) : p - bdq_pkg::PTR_W'(1);
  endfunction

  // advance the shadow deque by one command and queue the results it owes
  function automatic void predict_deque_results(input bdq_pkg::in_item_t item);
    bdq_pkg::out_item_t        res;
    logic [bdq_pkg::PTR_W-1:0] idx;
    res = '0;
    res.last = 1'b1;
    case (item.command)
      bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
        if (shadow_count == bdq_pkg::CNT_W'(bdq_pkg::DEPTH)) begin
          // full: store untouched, overflow reported
          res.status = bdq_pkg::STATUS_OVERFLOW;
        end else begin
          if (item.command == bdq_pkg::CMD_PUSH_FRONT) begin
            shadow_head = ptr_prev(shadow_head);
            shadow_store[shadow_head] = item.value;
          end else begin
            shadow_store[shadow_tail] = item.value;
            shadow_tail = ptr_next(shadow_tail);
          end
          shadow_count = shadow_count + bdq_pkg::CNT_W'(1);
          res.status = bdq_pkg::STATUS_OK;
        end
        res.occupancy = bdq_pkg::OCC_W'(shadow_count);
        due_results.push_back(res);
      end
      bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK: begin
        if (shadow_count == '0) begin
          res.status = bdq_pkg::STATUS_EMPTY;
        end else begin
          if (item.command == bdq_pkg::CMD_POP_FRONT) begin
            res.data = shadow_store[shadow_head];
            shadow_head = ptr_next(shadow_head);
          end else begin
            shadow_tail = ptr_prev(shadow_tail);
            res.data = shadow_store[shadow_tail];
          end
          shadow_count = shadow_count - bdq_pkg::CNT_W'(1);
          res.status = bdq_pkg::STATUS_OK;
        end
        res.occupancy = bdq_pkg::OCC_W'(shadow_count);
        due_results.push_back(res);
      end
      bdq_pkg::CMD_SHOW: begin
        res.occupancy = bdq_pkg::OCC_W'(shadow_count);
        if (shadow_count == '0) begin
          res.status = bdq_pkg::STATUS_EMPTY;
          due_results.push_back(res);
        end else begin
          // one result per held word, front to rear, last on the rear word
          idx = shadow_head;
          for (int w = 0; w < int'(shadow_count); w++) begin
            res.status = bdq_pkg::STATUS_OK;
            res.data   = shadow_store[idx];
            res.last   = (w == int'(shadow_count) - 1);
            due_results.push_back(res);
            idx = ptr_next(idx);
          end
        end
      end
      default: ; // unused codes: no state change, no result
    endcase
  endfunction

  // word mix weighted toward the extremes of the signed range
  function automatic logic signed [bdq_pkg::WORD_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      4:       return bdq_pkg::WORD_W'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // present one transaction, hold it until accepted, then predict its results
  task automatic send_command(input logic [bdq_pkg::CMD_W-1:0] cmd,
                              input logic signed [bdq_pkg::WORD_W-1:0] val);
    int unsigned       gap;
    bdq_pkg::in_item_t item;
    gap = send_idle ? $urandom_range(0, 14) : 0;
    item.command = cmd;
    item.value   = val;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    predict_deque_results(item);
  endtask

  // compare one taken result with the oldest owed one, field by field
  task automatic check_result(input bdq_pkg::out_item_t got);
    bdq_pkg::out_item_t want;
    if (due_results.size() == 0) begin
      $display("%0t ns: result with nothing owed: status %0d data %0d occupancy %0d last %0b",
               $time, got.status, got.data, got.occupancy, got.last);
      fail_count++;
    end else begin
      want = due_results.pop_front();
      if (got.status !== want.status) begin
        $display("%0t ns: status expected %0d actual %0d", $time, want.status, got.status);
        fail_count++;
      end
      if (got.data !== want.data) begin
        $display("%0t ns: data expected %0d actual %0d", $time, want.data, got.data);
        fail_count++;
      end
      if (got.occupancy !== want.occupancy) begin
        $display("%0t ns: occupancy expected %0d actual %0d", $time, want.occupancy,
                 got.occupancy);
        fail_count++;
      end
      if (got.last !== want.last) begin
        $display("%0t ns: last expected %0b actual %0b", $time, want.last, got.last);
        fail_count++;
      end
    end
  endtask

  // result side: random stall before each result, then take it and check it
  initial begin
    int unsigned stall;
    out_ready_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = recv_idle ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_result(out_data_o);
    end
  end

  // pops and shows on an empty deque all answer empty
  task automatic test_empty_deque();
    send_command(bdq_pkg::CMD_POP_FRONT, 32'sh7FFF_FFFF);
    send_command(bdq_pkg::CMD_POP_BACK, 32'sh8000_0000);
    send_command(bdq_pkg::CMD_SHOW, -32'sd1);
  endtask

  // fill to capacity from both ends, push on full, show all, pop both ends
  task automatic test_full_deque();
    send_command(bdq_pkg::CMD_PUSH_FRONT, 32'sh8000_0000);
    send_command(bdq_pkg::CMD_PUSH_BACK, 32'sh7FFF_FFFF);
    for (int i = 0; i < int'(bdq_pkg::DEPTH) - 2; i++)
      send_command((i % 2 == 0) ? bdq_pkg::CMD_PUSH_FRONT : bdq_pkg::CMD_PUSH_BACK,
                   random_word());
    send_command(bdq_pkg::CMD_PUSH_FRONT, 32'sd1);
    send_command(bdq_pkg::CMD_PUSH_BACK, -32'sd2);
    send_command(bdq_pkg::CMD_SHOW, '0);
    send_command(bdq_pkg::CMD_POP_FRONT, '0);
    send_command(bdq_pkg::CMD_POP_BACK, '0);
  endtask

  // random traffic in fill and drain phases so the deque hits full and empty often;
  // unused codes are sprinkled in as noise and do not count toward num_items
  task automatic test_random_traffic(input int num_items, input bit idle_in, input bit idle_out);
    int                        counted;
    int unsigned               roll;
    bit                        filling;
    logic [bdq_pkg::CMD_W-1:0] cmd;
    counted   = 0;
    filling   = 1'b1;
    send_idle = idle_in;
    recv_idle = idle_out;
    while (counted < num_items) begin
      // leave a phase quickly once at a bound, rarely otherwise
      if (shadow_count == bdq_pkg::CNT_W'(bdq_pkg::DEPTH) || shadow_count == '0)
        roll = $urandom_range(0, 5);
      else
        roll = $urandom_range(0, 39);
      if (roll == 0)
        filling = (shadow_count != bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
      roll = $urandom_range(0, 99);
      if (roll < 4)
        cmd = bdq_pkg::CMD_W'($urandom_range(5, 7));
      else if (roll < 12)
        cmd = bdq_pkg::CMD_SHOW;
      else if (roll < (filling ? 77 : 34))
        cmd = $urandom_range(0, 1) ? bdq_pkg::CMD_PUSH_FRONT : bdq_pkg::CMD_PUSH_BACK;
      else
        cmd = $urandom_range(0, 1) ? bdq_pkg::CMD_POP_FRONT : bdq_pkg::CMD_POP_BACK;
      send_command(cmd, random_word());
      if (cmd <= bdq_pkg::CMD_SHOW)
        counted++;
    end
  endtask

  // generous limit, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    shadow_head  = '0;
    shadow_tail  = '0;
    shadow_count = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_deque();
    test_full_deque();
    test_random_traffic(108, 1'b1, 1'b1);
    test_random_traffic(108, 1'b0, 1'b0);
    test_random_traffic(108, 1'b1, 1'b0);
    test_random_traffic(108, 1'b0, 1'b1);

    in_valid_i <= 1'b0;
    // drain with a ready receiver, then watch a while for stray results
    recv_idle = 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
